### design/fwc_pkg.sv
// ----------------------------------------------------------------------------
// fwc_pkg
// Types, codes and helper functions shared by the write-through cache files.
// ----------------------------------------------------------------------------
package fwc_pkg;

  localparam int unsigned WAY_COUNT = 4;
  localparam int unsigned WAY_W     = 2;
  localparam int unsigned SET_COUNT = 64;
  localparam int unsigned SET_W     = 6;
  localparam int unsigned WORD_W    = 2;
  localparam int unsigned TAG_W     = 19;
  localparam int unsigned LRU_W     = 6;
  localparam int unsigned ADDR_W    = 29;

  // LRU masks, kept in the six-bit layout (address-array bits 9..4).
  localparam logic [LRU_W-1:0] LRU_W3_SET = 6'h0B;
  localparam logic [LRU_W-1:0] LRU_W2_SET = 6'h14;
  localparam logic [LRU_W-1:0] LRU_W2_KEEP = 6'h3E;
  localparam logic [LRU_W-1:0] LRU_W1_SET = 6'h20;
  localparam logic [LRU_W-1:0] LRU_W1_KEEP = 6'h39;
  localparam logic [LRU_W-1:0] LRU_W0_KEEP = 6'h07;
  localparam logic [LRU_W-1:0] LRU_TWO_WAY = 6'h01;
  localparam logic [LRU_W-1:0] LRU_V2_MASK = 6'h15;
  localparam logic [LRU_W-1:0] LRU_V0_MASK = 6'h38;

  typedef enum logic [2:0] {
    OP_READ       = 3'd0,
    OP_WRITE      = 3'd1,
    OP_FILL       = 3'd2,
    OP_PURGE      = 3'd3,
    OP_ADDR_READ  = 3'd4,
    OP_ADDR_WRITE = 3'd5,
    OP_DATA_READ  = 3'd6,
    OP_DATA_WRITE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2,
    SZ_WIDE = 2'd3
  } size_e;

  typedef enum logic [1:0] {
    STS_DONE   = 2'd0,
    STS_FILL   = 2'd1,
    STS_BYPASS = 2'd2,
    STS_RSVD   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_TWO_WAY    = 2'd0,
    CFG_FETCH_DIS  = 2'd1,
    CFG_DATA_DIS   = 2'd2,
    CFG_WAY_SELECT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [2:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [1:0]        access_size;
    logic              is_fetch;
    logic [31:0]       write_data;
    logic [31:0]       fill_word_0;
    logic [31:0]       fill_word_1;
    logic [31:0]       fill_word_2;
    logic [31:0]       fill_word_3;
  } req_t;

  // Big-endian lane select; size three acts as long.
  function automatic logic [31:0] pick(logic [31:0] w, logic [1:0] a, logic [1:0] sz);
    logic [31:0] r;
    r = w;
    case (sz)
      SZ_BYTE: begin
        case (a)
          2'd0: r = {24'd0, w[31:24]};
          2'd1: r = {24'd0, w[23:16]};
          2'd2: r = {24'd0, w[15:8]};
          default: r = {24'd0, w[7:0]};
        endcase
      end
      SZ_WORD: r = a[1] ? {16'd0, w[15:0]} : {16'd0, w[31:16]};
      default: r = w;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] merge(logic [31:0] old, logic [1:0] a, logic [1:0] sz,
                                        logic [31:0] v);
    logic [31:0] r;
    r = v;
    case (sz)
      SZ_BYTE: begin
        case (a)
          2'd0: r = {v[7:0], old[23:0]};
          2'd1: r = {old[31:24], v[7:0], old[15:0]};
          2'd2: r = {old[31:16], v[7:0], old[7:0]};
          default: r = {old[31:8], v[7:0]};
        endcase
      end
      SZ_WORD: r = a[1] ? {old[31:16], v[15:0]} : {v[15:0], old[15:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic [LRU_W-1:0] touch(logic [LRU_W-1:0] l, logic [WAY_W-1:0] w);
    logic [LRU_W-1:0] r;
    case (w)
      2'd3: r = l | LRU_W3_SET;
      2'd2: r = (l | LRU_W2_SET) & LRU_W2_KEEP;
      2'd1: r = (l | LRU_W1_SET) & LRU_W1_KEEP;
      default: r = l & LRU_W0_KEEP;
    endcase
    return r;
  endfunction

  function automatic logic [WAY_W-1:0] victim(logic [LRU_W-1:0] l_in, logic two_way);
    logic [LRU_W-1:0] l;
    logic [WAY_W-1:0] r;
    l = two_way ? (l_in & LRU_TWO_WAY) : l_in;
    if ((l & LRU_W3_SET) == '0) r = 2'd3;
    else if ((l & LRU_V2_MASK) == LRU_TWO_WAY) r = 2'd2;
    else if ((l & LRU_V0_MASK) == LRU_V0_MASK) r = 2'd0;
    else r = 2'd1;
    return r;
  endfunction

endpackage

### design/fwc_if.sv
// ----------------------------------------------------------------------------
// fwc_req_if, fwc_rsp_if, fwc_cfg_if
// Valid/ready channels of the write-through cache.
// ----------------------------------------------------------------------------
interface fwc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [28:0] address;
  logic [1:0]  access_size;
  logic        is_fetch;
  logic [31:0] write_data;
  logic [31:0] fill_word_0;
  logic [31:0] fill_word_1;
  logic [31:0] fill_word_2;
  logic [31:0] fill_word_3;
  modport source (output valid, operation, address, access_size, is_fetch, write_data,
                  fill_word_0, fill_word_1, fill_word_2, fill_word_3, input ready);
  modport sink (input valid, operation, address, access_size, is_fetch, write_data,
                fill_word_0, fill_word_1, fill_word_2, fill_word_3, output ready);
endinterface

interface fwc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_data;
  logic        write_through;
  logic [28:0] line_address;
  modport source (output valid, status, read_data, write_through, line_address,
                  input ready);
  modport sink (input valid, status, read_data, write_through, line_address,
                output ready);
endinterface

interface fwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/fwc_ram.sv
// ----------------------------------------------------------------------------
// fwc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fwc_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### design/four_way_write_through_cache.sv
// ----------------------------------------------------------------------------
// four_way_write_through_cache
// 4-way, 64-set write-through cache with 16-byte lines and pseudo-LRU.
// ----------------------------------------------------------------------------
// For each word, the accept edge reads the tag, LRU and data RAMs of the
// addressed set; in execute the block evaluates hit, victim and sizing, and
// once the result register is free it writes back and loads that register.
// A new word is accepted only once the block is back in idle after the
// previous one has finished, so words are never overlapped.
// After reset the tag RAMs (valid bit included) and the LRU RAM are cleared
// one set per cycle, so no word is accepted until all 64 sets are cleared;
// data RAM contents are undefined until written.
module four_way_write_through_cache (
  input  logic clk_i,
  input  logic rst_ni,
  fwc_req_if.sink   req_i,
  fwc_rsp_if.source rsp_o,
  fwc_cfg_if.sink   cfg_i
);
  import fwc_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  logic   accept, fire;

  logic [SET_W-1:0] clr_q, clr_d;

  logic       two_way_q, fetch_dis_q, data_dis_q;
  logic [1:0] way_sel_q;

  logic [SET_W-1:0]  rd_set, set, wr_set;
  logic [WORD_W-1:0] word;
  logic [1:0]        size;
  logic [TAG_W-1:0]  atag;

  logic [TAG_W:0]   tag_rd [WAY_COUNT];
  logic [31:0]      dat_rd [WAY_COUNT][4];
  logic [LRU_W-1:0] lru_rd;

  logic [WAY_COUNT-1:0] tag_we;
  logic [TAG_W-1:0]     tag_wdata;
  logic                 tag_vbit;
  logic                 lru_we;
  logic [LRU_W-1:0]     lru_wdata;
  logic [3:0]           dat_we [WAY_COUNT];
  logic [31:0]          dat_wdata [4];

  logic [1:0]  status_d;
  logic [31:0] rdata_d;
  logic        wt_d;
  logic [28:0] line_d;
  logic        out_valid_q;

  // Per-way lookup values.
  logic [TAG_W-1:0]     tagv [WAY_COUNT];
  logic [WAY_COUNT-1:0] vld, match;
  logic                 hit;
  logic [WAY_W-1:0]     hit_way, vic_way;
  logic [LRU_W-1:0]     lru;
  logic [31:0]          arr_word;
  logic [7:0]           wb;

  assign accept = req_i.valid && req_i.ready;
  assign fire   = (state_q == ST_EXEC) && (!out_valid_q || rsp_o.ready);
  assign rd_set = req_i.address[9:4];
  assign set    = req_q.address[9:4];
  assign wr_set = (state_q == ST_CLEAR) ? clr_q : set;
  assign word   = req_q.address[3:2];
  assign size   = (req_q.access_size == SZ_WIDE) ? SZ_LONG : req_q.access_size;
  assign atag   = req_q.address[28:10];
  assign clr_d  = clr_q + 6'd1;
  assign cfg_i.ready = 1'b1;

  // Memories. A tag entry holds the tag above its valid bit.
  for (genvar w = 0; w < WAY_COUNT; w++) begin : g_way
    fwc_ram #(.DEPTH(SET_COUNT), .WIDTH(TAG_W + 1)) u_tag (
      .clk_i  (clk_i),
      .we_i   (tag_we[w]),
      .waddr_i(wr_set),
      .wdata_i({tag_wdata, tag_vbit}),
      .re_i   (accept),
      .raddr_i(rd_set),
      .rdata_o(tag_rd[w])
    );
    for (genvar b = 0; b < 4; b++) begin : g_bank
      fwc_ram #(.DEPTH(SET_COUNT), .WIDTH(32)) u_data (
        .clk_i  (clk_i),
        .we_i   (dat_we[w][b]),
        .waddr_i(wr_set),
        .wdata_i(dat_wdata[b]),
        .re_i   (accept),
        .raddr_i(rd_set),
        .rdata_o(dat_rd[w][b])
      );
    end
  end

  fwc_ram #(.DEPTH(SET_COUNT), .WIDTH(LRU_W)) u_lru (
    .clk_i  (clk_i),
    .we_i   (lru_we),
    .waddr_i(wr_set),
    .wdata_i(lru_wdata),
    .re_i   (accept),
    .raddr_i(rd_set),
    .rdata_o(lru_rd)
  );

  // State machine.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == 6'(SET_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: if (fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      default: req_i.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= '{operation: req_i.operation, address: req_i.address,
                 access_size: req_i.access_size, is_fetch: req_i.is_fetch,
                 write_data: req_i.write_data, fill_word_0: req_i.fill_word_0,
                 fill_word_1: req_i.fill_word_1, fill_word_2: req_i.fill_word_2,
                 fill_word_3: req_i.fill_word_3};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_way_q   <= 1'b0;
      fetch_dis_q <= 1'b0;
      data_dis_q  <= 1'b0;
      way_sel_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_TWO_WAY:    two_way_q   <= cfg_i.data[0];
        CFG_FETCH_DIS:  fetch_dis_q <= cfg_i.data[0];
        CFG_DATA_DIS:   data_dis_q  <= cfg_i.data[0];
        CFG_WAY_SELECT: way_sel_q   <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  // Lookup.
  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      tagv[w]  = tag_rd[w][TAG_W:1];
      vld[w]   = tag_rd[w][0];
      match[w] = vld[w] && (tagv[w] == atag);
    end
    lru = lru_rd;
    hit = |match;
    if (match[3]) hit_way = 2'd3;
    else if (match[2]) hit_way = 2'd2;
    else if (match[1]) hit_way = 2'd1;
    else hit_way = 2'd0;
    vic_way  = victim(lru, two_way_q);
    arr_word = {3'd0, tagv[way_sel_q], lru, 1'b0, vld[way_sel_q], 2'd0};
    wb       = req_q.write_data[7:0];
  end

  // Execute: results and write-back.
  always_comb begin
    tag_we    = '0;
    tag_wdata = atag;
    tag_vbit  = 1'b1;
    lru_we    = 1'b0;
    lru_wdata = lru;
    for (int w = 0; w < WAY_COUNT; w++) dat_we[w] = '0;
    dat_wdata[0] = req_q.fill_word_0;
    dat_wdata[1] = req_q.fill_word_1;
    dat_wdata[2] = req_q.fill_word_2;
    dat_wdata[3] = req_q.fill_word_3;
    status_d = STS_DONE;
    rdata_d  = '0;
    wt_d     = 1'b0;
    line_d   = '0;
    unique case (op_e'(req_q.operation))
      OP_READ: begin
        if (hit) begin
          lru_we  = 1'b1;
          lru_wdata = touch(lru, hit_way);
          rdata_d = pick(dat_rd[hit_way][word], req_q.address[1:0], size);
        end else if (req_q.is_fetch ? fetch_dis_q : data_dis_q) begin
          status_d = STS_BYPASS;
        end else begin
          status_d = STS_FILL;
          line_d   = {req_q.address[28:4], 4'd0};
        end
      end
      OP_WRITE: begin
        wt_d = 1'b1;
        if (hit) begin
          lru_we    = 1'b1;
          lru_wdata = touch(lru, hit_way);
          dat_we[hit_way][word] = 1'b1;
          dat_wdata[word] = merge(dat_rd[hit_way][word], req_q.address[1:0], size,
                                  req_q.write_data);
        end
      end
      OP_FILL: begin
        lru_we    = 1'b1;
        lru_wdata = touch(lru, vic_way);
        tag_we[vic_way] = 1'b1;
        dat_we[vic_way] = 4'hF;
        rdata_d = pick(dat_wdata[word], req_q.address[1:0], size);
      end
      OP_PURGE: begin
        // Matching entries are rewritten with the same tag and the valid bit clear.
        tag_vbit = 1'b0;
        for (int w = 0; w < WAY_COUNT; w++) tag_we[w] = (tagv[w] == atag);
      end
      OP_ADDR_READ: begin
        rdata_d = pick(arr_word, req_q.address[1:0], size);
      end
      OP_ADDR_WRITE: begin
        tag_we[way_sel_q] = 1'b1;
        tag_vbit = req_q.address[2];
        if (size == SZ_LONG) begin
          lru_we    = 1'b1;
          lru_wdata = req_q.write_data[9:4];
        end else if (size == SZ_WORD) begin
          lru_we    = req_q.address[1];
          lru_wdata = req_q.write_data[9:4];
        end else begin
          lru_we = req_q.address[1];
          // Byte writes update only the LRU bits in the addressed byte (5..4 or 3..0).
          lru_wdata = req_q.address[0] ? {lru[5:4], wb[7:4]} : {wb[1:0], lru[3:0]};
        end
      end
      OP_DATA_READ: begin
        rdata_d = pick(dat_rd[req_q.address[11:10]][word], req_q.address[1:0], size);
      end
      OP_DATA_WRITE: begin
        dat_we[req_q.address[11:10]][word] = 1'b1;
        dat_wdata[word] = merge(dat_rd[req_q.address[11:10]][word], req_q.address[1:0],
                                size, req_q.write_data);
      end
      default: ;
    endcase
    if (!fire) begin
      tag_we = '0;
      lru_we = 1'b0;
      for (int w = 0; w < WAY_COUNT; w++) dat_we[w] = '0;
    end
    if (state_q == ST_CLEAR) begin
      tag_we    = '1;
      tag_wdata = '0;
      tag_vbit  = 1'b0;
      lru_we    = 1'b1;
      lru_wdata = '0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_o.status        <= status_d;
      rsp_o.read_data     <= rdata_d;
      rsp_o.write_through <= wt_d;
      rsp_o.line_address  <= line_d;
    end
  end

  assign rsp_o.valid = out_valid_q;

  // The block never takes a word while one is being executed.
  a_no_accept_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> !req_i.ready) else $error("accept during execute");

  // Finishing an access always presents a result on the next cycle.
  a_fire_to_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q) else $error("result lost");

  // A fill request always carries a line-aligned address.
  a_line_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rsp_o.status == STS_FILL |-> rsp_o.line_address[3:0] == 4'd0)
    else $error("unaligned fill address");

  // A write-through word never reports a miss or bypass.
  a_wt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rsp_o.write_through |-> rsp_o.status == STS_DONE)
    else $error("write-through with miss status");

endmodule
